[hw/rtl/ster_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table search package
// Types and constants shared by the equal-range search block and its parts.
// ----------------------------------------------------------------------------
package ster_pkg;

    // Field widths fixed by the stream format
    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    // Item kinds carried in the input tuser bit
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST_GO,
        ST_FIRST_RUN,
        ST_LAST_GO,
        ST_LAST_RUN,
        ST_FINISH
    } t_state;

    // Commands from the sequencer to the shared probe unit
    typedef struct packed {
        logic start;
        logic go_right;
    } t_probe_ctl;

    // Status from the probe unit back to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } t_probe_sts;

endpackage

[hw/rtl/ster_table.sv]
// ----------------------------------------------------------------------------
// Sorted table storage
// Simple dual-port memory of signed entries: one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module ster_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [ster_pkg::DATA_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [ster_pkg::DATA_W-1:0] o_rd_data
);

    logic [ster_pkg::DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic [ster_pkg::DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/ster_probe.sv]
// ----------------------------------------------------------------------------
// Binary search probe unit
// Narrows a half-open window [lo, he) by one table probe per cycle and keeps
// the last matching position; searches for either end of the equal range.
// ----------------------------------------------------------------------------
module ster_probe #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ster_pkg::t_probe_ctl               i_ctl,
    input  logic [CW-1:0]                      i_count,
    input  logic signed [ster_pkg::DATA_W-1:0] i_key,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  logic signed [ster_pkg::DATA_W-1:0] i_rd_data,
    output ster_pkg::t_probe_sts               o_sts,
    output logic [AW-1:0]                      o_hit_idx
);

    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_he, n_he;
    logic [AW-1:0] r_mid, n_mid;
    logic          r_pend, n_pend;
    logic          r_go_right, n_go_right;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic          r_done, n_done;

    logic          w_eq;
    logic          w_lt;
    logic [CW-1:0] w_mid_p1;
    logic [CW-1:0] w_span;
    logic [CW-1:0] w_mid;
    logic          w_issue;

    // Window update from the entry read in the previous cycle
    always_comb begin
        w_eq       = (i_rd_data == i_key);
        w_lt       = (i_rd_data < i_key);
        w_mid_p1   = CW'(r_mid) + CW'(1);
        n_lo       = r_lo;
        n_he       = r_he;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_go_right = r_go_right;
        if (i_ctl.start) begin
            n_lo       = '0;
            n_he       = i_count;
            n_hit      = 1'b0;
            n_go_right = i_ctl.go_right;
        end else if (r_pend) begin
            if (w_eq) begin
                n_hit     = 1'b1;
                n_hit_idx = r_mid;
                if (r_go_right) begin
                    n_lo = w_mid_p1;
                end else begin
                    n_he = CW'(r_mid);
                end
            end else if (w_lt) begin
                n_lo = w_mid_p1;
            end else begin
                n_he = CW'(r_mid);
            end
        end

        // Next probe position: midpoint rounded towards the low end
        w_issue = (i_ctl.start || r_pend) && (n_lo < n_he);
        w_span  = n_he - n_lo - CW'(1);
        w_mid   = n_lo + (w_span >> 1);
        n_mid   = AW'(w_mid);
        n_pend  = w_issue;
        n_done  = (i_ctl.start || r_pend) && !w_issue;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_done <= n_done;
            r_hit  <= n_hit;
        end
    end

    // Window and result registers
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_he       <= n_he;
        r_mid      <= n_mid;
        r_go_right <= n_go_right;
        r_hit_idx  <= n_hit_idx;
    end

    assign o_rd_en    = w_issue;
    assign o_rd_addr  = n_mid;
    assign o_sts.done = r_done;
    assign o_sts.hit  = r_hit;
    assign o_hit_idx  = r_hit_idx;

endmodule

[hw/rtl/sorted_table_equal_range_search.sv]
// Load beat: table write at the accepting edge, no result, back to back.
// Query beat: one probe per cycle on the single read port, at most floor(log2(N))+1 per
// search for N entries in use; a key that the first search misses skips the second.
// Next beat taken while the result is valid; a stall holds back the next result, then the input.
// Reset clears the sequencer, output valid and entries_in_use, but not the table.
// ----------------------------------------------------------------------------
// Sorted table equal-range search
// Holds a table of ascending signed entries and answers key queries with the
// first and last matching positions and the match count.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: entries_in_use
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index [9:0], value [41:10], zero [47:42]
    input  logic [0:0]  s_tuser,   // action [0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // first_index [9:0], last_index [19:10],
                                   // match_count [30:20], zero [31]
    output logic [0:0]  m_tuser    // found [0]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    ster_pkg::t_state r_state, n_state;

    logic [ster_pkg::CNT_W-1:0]         r_cfg;
    logic signed [ster_pkg::DATA_W-1:0] r_key, n_key;
    logic [CW-1:0]                      r_count, n_count;
    logic                               r_first_hit, n_first_hit;
    logic [AW-1:0]                      r_first, n_first;
    logic                               r_last_hit, n_last_hit;
    logic [AW-1:0]                      r_last, n_last;
    logic                               r_out_valid, n_out_valid;
    logic                               r_out_found, n_out_found;
    logic [ster_pkg::IDX_W-1:0]         r_out_first, n_out_first;
    logic [ster_pkg::IDX_W-1:0]         r_out_last, n_out_last;
    logic [ster_pkg::CNT_W-1:0]         r_out_count, n_out_count;

    logic                          w_in_beat;
    logic                          w_action;
    logic [ster_pkg::IDX_W-1:0]    w_entry_index;
    logic [ster_pkg::DATA_W-1:0]   w_value;
    logic                          w_wr_en;
    logic [CW-1:0]                 w_count_clamped;
    logic [AW-1:0]                 w_last_sel;
    ster_pkg::t_probe_ctl          w_ctl;
    ster_pkg::t_probe_sts          w_sts;
    logic [AW-1:0]                 w_hit_idx;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic signed [ster_pkg::DATA_W-1:0] w_rd_data;

    // Input beat unpacking
    assign w_action      = s_tuser[0];
    assign w_entry_index = s_tdata[9:0];
    assign w_value       = s_tdata[41:10];
    assign w_in_beat     = s_tvalid && s_tready;
    assign w_wr_en       = w_in_beat && (w_action == ster_pkg::ACT_LOAD)
                           && (32'(w_entry_index) < DEPTH_W);

    // The search never looks beyond the table
    assign w_count_clamped = (32'(r_cfg) > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(r_cfg);

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Table storage
    ster_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_entry_index)),
        .i_wr_data (w_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared binary search unit, used for the low end of the range and, on a hit, the high end
    ster_probe #(
        .AW (AW),
        .CW (CW)
    ) u_probe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_count   (r_count),
        .i_key     (r_key),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_sts     (w_sts),
        .o_hit_idx (w_hit_idx)
    );

    // Sequencer: next state and outputs
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_count      = r_count;
        n_first_hit  = r_first_hit;
        n_first      = r_first;
        n_last_hit   = r_last_hit;
        n_last       = r_last;
        n_out_found  = r_out_found;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && !m_tready;
        w_ctl        = '0;
        s_tready     = 1'b0;
        w_last_sel   = r_last_hit ? r_last : r_first;

        case (r_state)
            ster_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (w_action == ster_pkg::ACT_QUERY)) begin
                    n_key   = w_value;
                    n_count = w_count_clamped;
                    n_state = ster_pkg::ST_FIRST_GO;
                end
            end
            ster_pkg::ST_FIRST_GO: begin
                w_ctl.start    = 1'b1;
                w_ctl.go_right = 1'b0;
                n_state        = ster_pkg::ST_FIRST_RUN;
            end
            ster_pkg::ST_FIRST_RUN: begin
                if (w_sts.done) begin
                    n_first_hit = w_sts.hit;
                    n_first     = w_hit_idx;
                    n_last_hit  = 1'b0;
                    n_state     = w_sts.hit ? ster_pkg::ST_LAST_GO : ster_pkg::ST_FINISH;
                end
            end
            ster_pkg::ST_LAST_GO: begin
                w_ctl.start    = 1'b1;
                w_ctl.go_right = 1'b1;
                n_state        = ster_pkg::ST_LAST_RUN;
            end
            ster_pkg::ST_LAST_RUN: begin
                if (w_sts.done) begin
                    n_last_hit = w_sts.hit;
                    n_last     = w_hit_idx;
                    n_state    = ster_pkg::ST_FINISH;
                end
            end
            ster_pkg::ST_FINISH: begin
                // Wait for the output register to be free
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_first_hit;
                    if (r_first_hit) begin
                        n_out_first = ster_pkg::IDX_W'(r_first);
                        n_out_last  = ster_pkg::IDX_W'(w_last_sel);
                        n_out_count = ster_pkg::CNT_W'(32'(w_last_sel) - 32'(r_first)
                                                       + 32'd1);
                    end else begin
                        n_out_first = '0;
                        n_out_last  = '0;
                        n_out_count = '0;
                    end
                    n_state = ster_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ster_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ster_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Query and result registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_count     <= n_count;
        r_first_hit <= n_first_hit;
        r_first     <= n_first;
        r_last_hit  <= n_last_hit;
        r_last      <= n_last;
        r_out_found <= n_out_found;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
    end

    // Result beat packing
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_found;
    assign m_tdata  = {1'b0, r_out_count, r_out_last, r_out_first};

endmodule

[hw/rtl/ster_checker.sv]
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Watches the ports of the search block and flags handshake and result slips.
// ----------------------------------------------------------------------------
module ster_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A missed key reports zero positions and count
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("missed key with non-zero result fields");

    // A query beat makes the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input taken while a query is being searched");

    // A load beat never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a load beat");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_table_equal_range_search ster_checker u_ster_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
